// File: sv/ulist_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ulist_pkg;

  localparam int unsigned KIND_W = 3;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned ITEM_W = 64;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned CNT_W  = 6;

  localparam int unsigned DEPTH_DEFAULT = 32;
  localparam logic [CNT_W-1:0] CAP_RESET = 6'd32;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_APPEND    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT_AT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE_AT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REMOVE_VAL = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SEARCH    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_READ_AT   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_COMPARE_AT = 3'd6;
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd7;

  // result status
  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_DUPLICATE = 3'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE     = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd4;

  // cell shift operations
  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_INS  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;

  typedef struct packed {
    logic              load;
    logic [1:0]        op;
    logic [CNT_W-1:0]  at;
    logic [ITEM_W-1:0] item;
    logic [CNT_W-1:0]  used;
    logic [POS_W-1:0]  pos;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: sv/ulist_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module ulist_cell import ulist_pkg::*; #(
  parameter int unsigned IDX  = 0,
  parameter int unsigned CMPW = 6
) (
  input  wire logic              clk,
  input  wire cell_ctl_t         ctl,
  input  wire logic [ITEM_W-1:0] left_in,
  input  wire logic [ITEM_W-1:0] right_in,
  output logic [ITEM_W-1:0]      entry,
  output logic                   match,
  output logic                   sel_hit,
  output logic [ITEM_W-1:0]      rd
);

  logic [ITEM_W-1:0] entry_r;
  logic [ITEM_W-1:0] rd_r;
  logic              match_r;
  logic              sel_r;

  logic [CMPW-1:0] idx_w;
  logic [CMPW-1:0] at_w;
  logic [CMPW-1:0] used_w;
  logic [CMPW-1:0] pos_w;

  assign idx_w  = CMPW'(IDX);
  assign at_w   = CMPW'(ctl.at);
  assign used_w = CMPW'(ctl.used);
  assign pos_w  = CMPW'(ctl.pos);

  // capture compare and read select when a request is taken
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      match_r <= (entry_r == ctl.item) && (idx_w < used_w);
      sel_r   <= (idx_w == pos_w);
      rd_r    <= entry_r;
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_INS: begin
        if (idx_w > at_w) begin
          entry_r <= left_in;
        end else if (idx_w == at_w) begin
          entry_r <= ctl.item;
        end
      end
      OP_DEL: begin
        if (idx_w >= at_w) begin
          entry_r <= right_in;
        end
      end
      default: begin
      end
    endcase
  end

  assign entry   = entry_r;
  assign match   = match_r;
  assign sel_hit = match_r & sel_r;
  assign rd      = sel_r ? rd_r : '0;

endmodule

`default_nettype wire

// File: sv/unique_ordered_list_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of distinct 64-bit values held in a row of DEPTH cells. In the
// cycle a request is transferred every cell compares its entry with the
// request value. In the evaluate state the matches are resolved and, once the
// output register is empty or out_ready is high, one result is written to it
// and the cells shift up or down in one step for inserts and removals. A new
// request is taken once that result has been written, even while it still
// waits on out_ready, and not before. The entry count and capacity are 6 bits
// and only the first 32 entries are reachable by position. The user must
// write capacity through the cfg port only while no request is in flight; the
// block itself does not enforce this. Capacity is saturated to DEPTH.
module unique_ordered_list_engine_core import ulist_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst_n,

  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CNT_W-1:0]  cfg_capacity,

  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic [POS_W-1:0]  in_position,
  input  wire logic [ITEM_W-1:0] in_item,

  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [STAT_W-1:0]      out_status,
  output logic                   out_hit,
  output logic [POS_W-1:0]       out_hit_index,
  output logic [ITEM_W-1:0]      out_read_data,
  output logic [CNT_W-1:0]       out_count,
  output logic                   out_empty_res,
  output logic                   out_full_res
);

  localparam int unsigned DW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (DW > CNT_W) ? DW : CNT_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EVAL = 1'b1;

  logic state_r, state_nxt;
  logic [CNT_W-1:0] capacity_r;
  logic [CNT_W-1:0] used_r;

  logic [KIND_W-1:0] req_kind_r;
  logic [POS_W-1:0]  req_pos_r;
  logic [ITEM_W-1:0] req_item_r;

  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic              out_hit_r;
  logic [POS_W-1:0]  out_hit_index_r;
  logic [ITEM_W-1:0] out_read_data_r;
  logic [CNT_W-1:0]  out_count_r;
  logic              out_empty_r;
  logic              out_full_r;

  cell_ctl_t ctl;

  logic [ITEM_W-1:0] entry_a [DEPTH];
  logic [ITEM_W-1:0] rd_a    [DEPTH];
  logic [DEPTH-1:0]  match_v;
  logic [DEPTH-1:0]  sel_v;

  logic              in_xfer;
  logic              commit;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid & in_ready;
  assign commit    = (state_r == ST_EVAL) & (~out_valid_r | out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_valid) begin
      capacity_r <= cfg_capacity;
    end
  end

  // cell row
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [ITEM_W-1:0] left_w;
    logic [ITEM_W-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = ctl.item;
    end else begin : g_mid_l
      assign left_w = entry_a[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = entry_a[g];
    end else begin : g_mid_r
      assign right_w = entry_a[g+1];
    end
    ulist_cell #(
      .IDX  (g),
      .CMPW (CMPW)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .left_in  (left_w),
      .right_in (right_w),
      .entry    (entry_a[g]),
      .match    (match_v[g]),
      .sel_hit  (sel_v[g]),
      .rd       (rd_a[g])
    );
  end

  // resolve matches; at most one valid entry can match since values are distinct
  logic              found;
  logic              cmp_hit;
  logic [CNT_W-1:0]  where;
  logic [ITEM_W-1:0] rd_or;

  always_comb begin
    where = '0;
    rd_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match_v[i]) begin
        where = where | CNT_W'(i);
      end
      rd_or = rd_or | rd_a[i];
    end
    found   = |match_v;
    cmp_hit = |sel_v;
  end

  logic [CNT_W-1:0]  cap;
  logic [CNT_W-1:0]  pos_c;
  logic              full_now;
  logic              pos_out;

  assign cap      = (CMPW'(capacity_r) > CMPW'(DEPTH)) ? CNT_W'(DEPTH) : capacity_r;
  assign pos_c    = CNT_W'(req_pos_r);
  assign full_now = (used_r >= cap);
  assign pos_out  = (pos_c >= used_r);

  logic [STAT_W-1:0] res_status;
  logic              res_hit;
  logic [POS_W-1:0]  res_hidx;
  logic [ITEM_W-1:0] res_rdata;
  logic [CNT_W-1:0]  res_used;
  logic [1:0]        res_op;
  logic [CNT_W-1:0]  res_at;

  always_comb begin
    res_status = STAT_OK;
    res_hit    = 1'b0;
    res_hidx   = '0;
    res_rdata  = '0;
    res_used   = used_r;
    res_op     = OP_HOLD;
    res_at     = '0;
    unique case (req_kind_r)
      KIND_APPEND, KIND_INSERT_AT: begin
        if (full_now) begin
          res_status = STAT_FULL;
        end else if (found) begin
          res_status = STAT_DUPLICATE;
        end else if ((req_kind_r == KIND_INSERT_AT) && (pos_c > used_r)) begin
          res_status = STAT_RANGE;
        end else begin
          res_op   = OP_INS;
          res_at   = (req_kind_r == KIND_APPEND) ? used_r : pos_c;
          res_used = used_r + 1'b1;
        end
      end
      KIND_REMOVE_AT: begin
        if (pos_out) begin
          res_status = STAT_RANGE;
        end else begin
          res_op   = OP_DEL;
          res_at   = pos_c;
          res_used = used_r - 1'b1;
        end
      end
      KIND_REMOVE_VAL: begin
        if (found) begin
          res_op   = OP_DEL;
          res_at   = where;
          res_used = used_r - 1'b1;
        end else begin
          res_status = STAT_NOT_FOUND;
        end
      end
      KIND_SEARCH: begin
        if (found) begin
          res_hit  = 1'b1;
          res_hidx = where[POS_W-1:0];
        end else begin
          res_status = STAT_NOT_FOUND;
        end
      end
      KIND_READ_AT: begin
        if (pos_out) begin
          res_status = STAT_RANGE;
        end else begin
          res_rdata = rd_or;
        end
      end
      KIND_COMPARE_AT: begin
        if (pos_out) begin
          res_status = STAT_RANGE;
        end else begin
          res_hit = cmp_hit;
        end
      end
      default: begin
        res_used = '0;
      end
    endcase
  end

  always_comb begin
    ctl.load = in_xfer;
    ctl.op   = commit ? res_op : OP_HOLD;
    ctl.at   = res_at;
    ctl.item = in_xfer ? in_item : req_item_r;
    ctl.used = used_r;
    ctl.pos  = in_position;
  end

  always_comb begin
    state_nxt = state_r;
    if (in_xfer) begin
      state_nxt = ST_EVAL;
    end else if (commit) begin
      state_nxt = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        used_r      <= res_used;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_kind_r <= in_kind;
      req_pos_r  <= in_position;
      req_item_r <= in_item;
    end
    if (commit) begin
      out_status_r    <= res_status;
      out_hit_r       <= res_hit;
      out_hit_index_r <= res_hidx;
      out_read_data_r <= res_rdata;
      out_count_r     <= res_used;
      out_empty_r     <= (res_used == '0);
      out_full_r      <= (res_used >= cap);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_hit       = out_hit_r;
  assign out_hit_index = out_hit_index_r;
  assign out_read_data = out_read_data_r;
  assign out_count     = out_count_r;
  assign out_empty_res = out_empty_r;
  assign out_full_res  = out_full_r;

endmodule

`default_nettype wire
